/* hw/rtl/rau_pkg.sv */
package rau_pkg;

  localparam int NUM_W  = 33;
  localparam int DEN_W  = 32;
  localparam int PROD_W = 34;
  localparam int OPND_W = 17;
  localparam int K_W    = 6;
  localparam int CNT_W  = 6;
  localparam int STEP_W = 4;

  // One quotient bit per pass covers the widest dividend.
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(NUM_W);

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_MUL = 2'd1;
  localparam logic [1:0] FUNC_CMP = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] left_num;
    logic [15:0]        left_den;
    logic signed [15:0] right_num;
    logic [15:0]        right_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] res_num;
    logic [DEN_W-1:0]        res_den;
    logic                    equal;
  } rau_out_t;

  // Datapath operation selected by the current control word.
  typedef enum logic [3:0] {
    OP_IDLE    = 4'd0,
    OP_MUL_A   = 4'd1,
    OP_MUL_B   = 4'd2,
    OP_MUL_C   = 4'd3,
    OP_SETUP   = 4'd4,
    OP_TWOS    = 4'd5,
    OP_REDUCE  = 4'd6,
    OP_SCALE   = 4'd7,
    OP_DIVINIT = 4'd8,
    OP_DIV     = 4'd9,
    OP_EMIT    = 4'd10,
    OP_NOP     = 4'd11
  } op_t;

  // Jump condition of a control word; when true the step counter loads the target.
  typedef enum logic [3:0] {
    C_NEVER     = 4'd0,
    C_ALWAYS    = 4'd1,
    C_NO_IN     = 4'd2,
    C_SHORT     = 4'd3,
    C_BOTH_EVEN = 4'd4,
    C_Y_NZ      = 4'd5,
    C_K_NZ      = 4'd6,
    C_DIV_MORE  = 4'd7,
    C_OUT_BUSY  = 4'd8
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic short_path;
    logic both_even;
    logic y_nz;
    logic k_nz;
    logic div_more;
    logic out_busy;
  } stat_t;

endpackage

/* hw/rtl/rau_sequencer.sv */
module rau_sequencer (
  input  logic           clk,
  input  logic           rst_n,
  input  rau_pkg::stat_t stat,
  output rau_pkg::op_t   op
);

  localparam logic [rau_pkg::STEP_W-1:0] S_IDLE    = 4'd0;
  localparam logic [rau_pkg::STEP_W-1:0] S_MUL_A   = 4'd1;
  localparam logic [rau_pkg::STEP_W-1:0] S_MUL_B   = 4'd2;
  localparam logic [rau_pkg::STEP_W-1:0] S_MUL_C   = 4'd3;
  localparam logic [rau_pkg::STEP_W-1:0] S_SETUP   = 4'd4;
  localparam logic [rau_pkg::STEP_W-1:0] S_TWOS    = 4'd5;
  localparam logic [rau_pkg::STEP_W-1:0] S_REDUCE  = 4'd6;
  localparam logic [rau_pkg::STEP_W-1:0] S_SCALE   = 4'd7;
  localparam logic [rau_pkg::STEP_W-1:0] S_DIVINIT = 4'd8;
  localparam logic [rau_pkg::STEP_W-1:0] S_DIV     = 4'd9;
  localparam logic [rau_pkg::STEP_W-1:0] S_EMIT    = 4'd10;
  localparam logic [rau_pkg::STEP_W-1:0] S_RET     = 4'd11;

  logic [rau_pkg::STEP_W-1:0] step_r, step_nxt;
  rau_pkg::ucode_t            word;
  logic                       jump;

  // Program ROM.
  always_comb begin
    unique case (step_r)
      S_IDLE:    word = '{rau_pkg::OP_IDLE,    rau_pkg::C_NO_IN,     S_IDLE};
      S_MUL_A:   word = '{rau_pkg::OP_MUL_A,   rau_pkg::C_NEVER,     S_IDLE};
      S_MUL_B:   word = '{rau_pkg::OP_MUL_B,   rau_pkg::C_NEVER,     S_IDLE};
      S_MUL_C:   word = '{rau_pkg::OP_MUL_C,   rau_pkg::C_NEVER,     S_IDLE};
      S_SETUP:   word = '{rau_pkg::OP_SETUP,   rau_pkg::C_SHORT,     S_EMIT};
      S_TWOS:    word = '{rau_pkg::OP_TWOS,    rau_pkg::C_BOTH_EVEN, S_TWOS};
      S_REDUCE:  word = '{rau_pkg::OP_REDUCE,  rau_pkg::C_Y_NZ,      S_REDUCE};
      S_SCALE:   word = '{rau_pkg::OP_SCALE,   rau_pkg::C_K_NZ,      S_SCALE};
      S_DIVINIT: word = '{rau_pkg::OP_DIVINIT, rau_pkg::C_NEVER,     S_IDLE};
      S_DIV:     word = '{rau_pkg::OP_DIV,     rau_pkg::C_DIV_MORE,  S_DIV};
      S_EMIT:    word = '{rau_pkg::OP_EMIT,    rau_pkg::C_OUT_BUSY,  S_EMIT};
      S_RET:     word = '{rau_pkg::OP_NOP,     rau_pkg::C_ALWAYS,    S_IDLE};
      default:   word = '{rau_pkg::OP_NOP,     rau_pkg::C_ALWAYS,    S_IDLE};
    endcase
  end

  always_comb begin
    unique case (word.cond)
      rau_pkg::C_NEVER:     jump = 1'b0;
      rau_pkg::C_ALWAYS:    jump = 1'b1;
      rau_pkg::C_NO_IN:     jump = !stat.in_valid;
      rau_pkg::C_SHORT:     jump = stat.short_path;
      rau_pkg::C_BOTH_EVEN: jump = stat.both_even;
      rau_pkg::C_Y_NZ:      jump = stat.y_nz;
      rau_pkg::C_K_NZ:      jump = stat.k_nz;
      rau_pkg::C_DIV_MORE:  jump = stat.div_more;
      rau_pkg::C_OUT_BUSY:  jump = stat.out_busy;
      default:              jump = 1'b1;
    endcase
    step_nxt = jump ? word.target : step_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign op = word.op;

endmodule

/* hw/rtl/rational_arithmetic_unit.sv */
// Rational arithmetic unit: adds, multiplies or compares two fractions.
// Input channel in_valid / in_stall / in_item carries func and the two
// fractions; result channel out_valid / out_stall / out_item carries the
// reduced numerator, the denominator and the equal flag. Every item yields
// exactly one result, in order.
// A microcoded sequencer steps one item at a time through a single 17x17
// multiplier (three products), a binary gcd (strip common twos, then
// shift / subtract until the second operand is zero, then scale back),
// and a dual restoring divider that forms both quotients over 33 passes.
// A compare or a zero numerator skips the gcd and the divider and goes
// straight to the result. The next item is accepted once its predecessor's
// result is loaded into the output register and the sequencer has returned
// to idle through its return step.
// The output register holds a result while out_stall is high; the block
// accepts and works on the next item meanwhile and waits to emit it.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// any pending result.
module rational_arithmetic_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rau_pkg::rau_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output rau_pkg::rau_out_t out_item
);

  localparam int NW = rau_pkg::NUM_W;
  localparam int PW = rau_pkg::PROD_W;

  rau_pkg::op_t     op;
  rau_pkg::stat_t   stat;
  rau_pkg::rau_in_t item_r;
  rau_pkg::rau_out_t out_r;
  logic             out_valid_r;

  logic signed [rau_pkg::OPND_W-1:0] ma, mb;
  logic signed [PW-1:0]              mprod, prod_r, t_r, sum;
  logic [PW-1:0]                     abs_sum;

  logic [NW-1:0]       mag_r, den_r, x_r, y_r, rm_r, rd_r;
  logic [rau_pkg::K_W-1:0]   k_r;
  logic [rau_pkg::CNT_W-1:0] cnt_r;
  logic                neg_r, eq_r, short_r;

  logic          in_take, out_busy, out_load, short_now;
  logic          x_gt_y;
  logic [NW-1:0] xy_min, xy_diff;
  logic [NW:0]   dm_sh, dd_sh, dm_sub, dd_sub;
  logic          dm_ge, dd_ge;
  logic [NW-1:0] neg_mag;

  rau_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  assign in_stall = (op != rau_pkg::OP_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_busy = out_valid_r && out_stall;
  assign out_load = (op == rau_pkg::OP_EMIT) && !out_busy;

  // Operand select for the shared multiplier: cross product (numerator
  // product for a multiply), second cross product, denominator product.
  always_comb begin
    case (op)
      rau_pkg::OP_MUL_A: begin
        ma = {item_r.left_num[15], item_r.left_num};
        mb = (item_r.func == rau_pkg::FUNC_MUL) ? {item_r.right_num[15], item_r.right_num}
                                                : {1'b0, item_r.right_den};
      end
      rau_pkg::OP_MUL_B: begin
        ma = {item_r.right_num[15], item_r.right_num};
        mb = {1'b0, item_r.left_den};
      end
      default: begin
        ma = {1'b0, item_r.left_den};
        mb = {1'b0, item_r.right_den};
      end
    endcase
  end

  assign mprod   = PW'(ma * mb);
  assign sum     = (item_r.func == rau_pkg::FUNC_ADD) ? t_r + prod_r : t_r;
  assign abs_sum = sum[PW-1] ? PW'(-sum) : sum;

  assign short_now = !((item_r.func == rau_pkg::FUNC_ADD) ||
                       (item_r.func == rau_pkg::FUNC_MUL)) || (mag_r == '0);

  // Binary gcd step on odd operands: keep the smaller, replace the other
  // by the (even) difference.
  assign x_gt_y  = x_r > y_r;
  assign xy_min  = x_gt_y ? y_r : x_r;
  assign xy_diff = x_gt_y ? x_r - y_r : y_r - x_r;

  // Restoring division of mag_r and den_r by the gcd in x_r.
  assign dm_sh  = {rm_r, mag_r[NW-1]};
  assign dd_sh  = {rd_r, den_r[NW-1]};
  assign dm_sub = dm_sh - {1'b0, x_r};
  assign dd_sub = dd_sh - {1'b0, x_r};
  assign dm_ge  = dm_sh >= {1'b0, x_r};
  assign dd_ge  = dd_sh >= {1'b0, x_r};

  assign neg_mag = NW'(-mag_r);

  always_comb begin
    stat.in_valid   = in_valid;
    stat.short_path = short_now;
    stat.both_even  = !x_r[0] && !y_r[0] && (y_r != '0);
    stat.y_nz       = (y_r != '0);
    stat.k_nz       = (k_r != '0);
    stat.div_more   = (cnt_r != rau_pkg::CNT_W'(1));
    stat.out_busy   = out_busy;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_item;
    end
    case (op)
      rau_pkg::OP_MUL_A: begin
        prod_r <= mprod;
      end
      rau_pkg::OP_MUL_B: begin
        prod_r <= mprod;
        t_r    <= prod_r;
      end
      rau_pkg::OP_MUL_C: begin
        prod_r <= mprod;
        mag_r  <= abs_sum[NW-1:0];
        neg_r  <= sum[PW-1];
        eq_r   <= (t_r == prod_r);
      end
      rau_pkg::OP_SETUP: begin
        den_r   <= prod_r[NW-1:0];
        x_r     <= mag_r;
        y_r     <= prod_r[NW-1:0];
        k_r     <= '0;
        short_r <= short_now;
      end
      rau_pkg::OP_TWOS: begin
        if (stat.both_even) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + rau_pkg::K_W'(1);
        end
      end
      rau_pkg::OP_REDUCE: begin
        if (y_r != '0) begin
          if (!x_r[0]) begin
            x_r <= x_r >> 1;
          end else if (!y_r[0]) begin
            y_r <= y_r >> 1;
          end else begin
            x_r <= xy_min;
            y_r <= xy_diff;
          end
        end
      end
      rau_pkg::OP_SCALE: begin
        if (k_r != '0) begin
          x_r <= x_r << 1;
          k_r <= k_r - rau_pkg::K_W'(1);
        end
      end
      rau_pkg::OP_DIVINIT: begin
        rm_r  <= '0;
        rd_r  <= '0;
        cnt_r <= rau_pkg::DIV_STEPS;
      end
      rau_pkg::OP_DIV: begin
        rm_r  <= dm_ge ? dm_sub[NW-1:0] : dm_sh[NW-1:0];
        rd_r  <= dd_ge ? dd_sub[NW-1:0] : dd_sh[NW-1:0];
        mag_r <= {mag_r[NW-2:0], dm_ge};
        den_r <= {den_r[NW-2:0], dd_ge};
        cnt_r <= cnt_r - rau_pkg::CNT_W'(1);
      end
      default: begin
      end
    endcase
    if (out_load) begin
      if (short_r) begin
        out_r.res_num <= '0;
        out_r.res_den <= rau_pkg::DEN_W'(1);
        out_r.equal   <= (item_r.func == rau_pkg::FUNC_CMP) && eq_r;
      end else begin
        out_r.res_num <= neg_r ? neg_mag : mag_r;
        out_r.res_den <= den_r[rau_pkg::DEN_W-1:0];
        out_r.equal   <= 1'b0;
      end
    end
  end

  // Hold the result until taken; drop it on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // An accepted item starts the program at the first product.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (op == rau_pkg::OP_MUL_A))
    else $error("program did not start after accept");

  // The divider never runs with a zero gcd.
  a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (op == rau_pkg::OP_DIV) |-> (x_r != '0))
    else $error("division by zero gcd");

  // A zero denominator result is always a unit numerator.
  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.res_den == '0)) |->
      ((out_item.res_num == NW'(1)) || (out_item.res_num == {NW{1'b1}})))
    else $error("zero denominator with non-unit numerator");

  // An equal flag comes only with the compare result 0/1.
  a_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.equal) |->
      ((out_item.res_num == '0) && (out_item.res_den == rau_pkg::DEN_W'(1))))
    else $error("equal flag on non-compare result");

endmodule
